// ===== src/wtsv_pkg.sv =====
// Package for the wavetable tone synth: opcodes, note step table and shared widths.
package wtsv_pkg;

	localparam int SampleW = 8;
	localparam int PhaseW  = 32;
	localparam int StepW   = 30;
	localparam int NoteW   = 4;
	localparam int OpW     = 2;
	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 64;
	localparam int WaveWords = 4;

	// Opcodes of an input beat
	localparam logic [OpW-1:0] OP_TICK      = 2'd0;
	localparam logic [OpW-1:0] OP_PLAY      = 2'd1;
	localparam logic [OpW-1:0] OP_PLAY_NOTE = 2'd2;
	localparam logic [OpW-1:0] OP_STOP      = 2'd3;

	// Configuration register indexes
	localparam logic [CfgAddrW-1:0] REG_WAVE_0   = 3'd0;
	localparam logic [CfgAddrW-1:0] REG_WAVE_1   = 3'd1;
	localparam logic [CfgAddrW-1:0] REG_WAVE_2   = 3'd2;
	localparam logic [CfgAddrW-1:0] REG_WAVE_3   = 3'd3;
	localparam logic [CfgAddrW-1:0] REG_TARGET   = 3'd4;

	localparam logic [CfgDataW-1:0] WAVE_FILL    = 64'h8080_8080_8080_8080;
	localparam logic [SampleW-1:0]  MID_LEVEL    = 8'd128;
	localparam logic [SampleW-1:0]  TARGET_RESET = 8'd255;
	localparam logic [SampleW-1:0]  VOL_STEP     = 8'd8;
	localparam logic [SampleW-1:0]  VOL_STEP_MAX = 8'd247;
	localparam logic [StepW-1:0]    DEFAULT_STEP = 30'd140461537;

	typedef logic [StepW-1:0] step_t;

	// Octave 4 steps; octave 5 doubles them, unknown codes fall back to DO4
	function automatic step_t step_for_note(input logic [NoteW-1:0] note);
		step_t base;
		logic [2:0] deg;
		base = DEFAULT_STEP;
		deg  = (note < 4'd7) ? note[2:0] : 3'(note - 4'd7);
		case (deg)
			3'd0: base = 30'd140461537;
			3'd1: base = 30'd157657512;
			3'd2: base = 30'd176968759;
			3'd3: base = 30'd187491429;
			3'd4: base = 30'd210453398;
			3'd5: base = 30'd236223201;
			3'd6: base = 30'd265149806;
			default: base = DEFAULT_STEP;
		endcase
		if (note >= 4'd14) begin
			return DEFAULT_STEP;
		end
		if (note >= 4'd7) begin
			return {base[StepW-2:0], 1'b0};
		end
		return base;
	endfunction

endpackage

// ===== src/wavetable_tone_synth_volume_ramp_core.sv =====
// Top level of the wavetable tone synth: command decode, oscillator state, output register.
// A tick or stop beat's sample is registered on the edge that accepts it and shows on m_tdata.
// The core takes one input beat per cycle; the single output register stalls the input
//   only while a sample waits and m_tready is low.
// Play beats and ticks while stopped update state only and produce no output beat.
// Reset (arst_n low, asynchronous): phase 0, step DO4, volume 0, stopped, wavetable
//   words 0x80 in every byte, target volume 255, no output beat pending.
module wavetable_tone_synth_volume_ramp_core
	import wtsv_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [3:0] note, [7:4] zero
	input  logic [OpW-1:0]      s_tuser,   // [1:0] opcode
	// output stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SampleW-1:0]  m_tdata,   // [7:0] sample
	// configuration write port
	input  logic                cfg_wr_en,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	logic [CfgDataW-1:0] wave_q [WaveWords];
	logic [SampleW-1:0]  target_q;
	logic [PhaseW-1:0]   phase_q;
	step_t               step_q;
	logic [SampleW-1:0]  volume_q;
	logic                playing_q;
	logic                m_tvalid_q;
	logic [SampleW-1:0]  sample_s1;

	logic                in_fire;
	logic [OpW-1:0]      opcode;
	logic [NoteW-1:0]    note;
	logic [SampleW-1:0]  raw;
	logic [CfgDataW-1:0] wave_word;
	logic [SampleW-1:0]  vol_next;
	logic [SampleW-1:0]  scaled;
	logic                emit;
	logic [SampleW-1:0]  result;

	assign opcode   = s_tuser;
	assign note     = s_tdata[NoteW-1:0];
	assign s_tready = ~m_tvalid_q | m_tready;
	assign in_fire  = s_tvalid & s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = sample_s1;

	// Wavetable byte selected by the top five phase bits
	assign wave_word = wave_q[phase_q[PhaseW-1:PhaseW-2]];
	assign raw       = wave_word[{phase_q[PhaseW-3:PhaseW-5], 3'd0} +: SampleW];

	// Volume ramp toward the target, applied before scaling
	always_comb begin
		vol_next = volume_q;
		if (volume_q < target_q) begin
			vol_next = (volume_q <= VOL_STEP_MAX) ? 8'(volume_q + VOL_STEP) : target_q;
		end
	end

	wtsv_scale u_scale (
		.raw    (raw),
		.vol    (vol_next),
		.sample (scaled)
	);

	// Does this beat produce a sample, and which one
	always_comb begin
		emit   = 1'b0;
		result = MID_LEVEL;
		unique case (opcode)
			OP_TICK: begin
				emit   = playing_q;
				result = scaled;
			end
			OP_STOP: begin
				emit   = 1'b1;
				result = MID_LEVEL;
			end
			default: begin
				emit   = 1'b0;
				result = MID_LEVEL;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WaveWords; i++) begin
				wave_q[i] <= WAVE_FILL;
			end
			target_q <= TARGET_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_WAVE_0: wave_q[0] <= cfg_wdata;
				REG_WAVE_1: wave_q[1] <= cfg_wdata;
				REG_WAVE_2: wave_q[2] <= cfg_wdata;
				REG_WAVE_3: wave_q[3] <= cfg_wdata;
				REG_TARGET: target_q  <= cfg_wdata[SampleW-1:0];
				default: ;
			endcase
		end
	end

	// Oscillator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			step_q    <= DEFAULT_STEP;
			volume_q  <= '0;
			playing_q <= 1'b0;
		end else if (in_fire) begin
			unique case (opcode)
				OP_TICK: begin
					if (playing_q) begin
						volume_q <= vol_next;
						phase_q  <= phase_q + {{(PhaseW-StepW){1'b0}}, step_q};
					end
				end
				OP_PLAY, OP_PLAY_NOTE: begin
					phase_q   <= '0;
					volume_q  <= '0;
					playing_q <= 1'b1;
					if (opcode == OP_PLAY_NOTE) begin
						step_q <= step_for_note(note);
					end
				end
				default: begin
					phase_q   <= '0;
					volume_q  <= '0;
					playing_q <= 1'b0;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (in_fire) begin
			m_tvalid_q <= emit;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			sample_s1 <= result;
		end
	end

	// A stop beat leaves silence pending and the oscillator idle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && opcode == OP_STOP |=> m_tvalid && m_tdata == MID_LEVEL && !playing_q)
		else $error("stop did not produce silence");

	// A play beat restarts phase and volume
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (opcode == OP_PLAY || opcode == OP_PLAY_NOTE)
		|=> phase_q == '0 && volume_q == '0 && playing_q && !m_tvalid)
		else $error("play did not restart oscillator");

	// An output beat only appears after an input beat
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(in_fire))
		else $error("output beat without input beat");

	// A tick while stopped changes nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && opcode == OP_TICK && !playing_q
		|=> $stable(phase_q) && $stable(volume_q) && !m_tvalid)
		else $error("tick while stopped changed state");

endmodule

// ===== src/wtsv_scale.sv =====
// Volume scaler: centers a wavetable byte on 128 and scales it by volume/255.
module wtsv_scale
	import wtsv_pkg::*;
(
	input  logic [SampleW-1:0] raw,
	input  logic [SampleW-1:0] vol,
	output logic [SampleW-1:0] sample
);

	logic                 neg;
	logic [SampleW-1:0]   mag;
	logic [15:0]          prod;
	logic [16:0]          sum;
	logic [SampleW-1:0]   quot;

	// Magnitude of raw - 128 (0..128) and its sign
	assign neg = ~raw[SampleW-1];
	assign mag = neg ? 8'(MID_LEVEL - raw) : 8'(raw - MID_LEVEL);

	// Product below 32768, so floor(x/255) = (x + 1 + (x >> 8)) >> 8
	assign prod = {8'd0, mag} * {8'd0, vol};
	assign sum  = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};
	assign quot = sum[15:8];

	// Truncation toward zero: apply the sign after dividing the magnitude
	assign sample = neg ? 8'(MID_LEVEL - quot) : 8'(MID_LEVEL + quot);

endmodule
